// File: hdl/bis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image sampler package
// Shared sizes, transaction types and fixed-point helpers for the sampler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CH_W      = 16;
  localparam int PIX_W     = 3 * CH_W;
  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 12;
  localparam int POS_SHIFT = FRAC_W + 3;
  localparam int PU_W      = COORD_W + COL_W;
  localparam int PV_W      = COORD_W + ROW_W;
  localparam int WGT_W     = 2 * (FRAC_W + 1);
  localparam int ACC_W     = WGT_W + 1 + CH_W;
  localparam int OUT_W     = 13;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 8;

  localparam int ONE_Q12   = 4096;
  localparam int COORD_LIM = 16384;
  localparam int RND_BIT   = 23;
  localparam int RES_SHIFT = 24;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                      cmd;
    logic [7:0]                pix_col;
    logic [7:0]                pix_row;
    logic signed [CH_W-1:0]    red_in;
    logic signed [CH_W-1:0]    green_in;
    logic signed [CH_W-1:0]    blue_in;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;
    logic                      last_in;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             last_out;
  } out_t;

  typedef struct packed {
    logic              is_sample;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  x0;
    logic [COL_W-1:0]  x1;
    logic [ROW_W-1:0]  y0;
    logic [ROW_W-1:0]  y1;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              last;
  } cq_t;

  // Register value minus one, with zero read as one and large values capped.
  function automatic int clamp_m1(logic [CFG_W-1:0] v, int maxv);
    int s;
    s = int'(v);
    if (s < 1) s = 1;
    if (s > maxv) s = maxv;
    return s - 1;
  endfunction

  // Clamped coordinate offset into the range 0..32768.
  function automatic logic [COORD_W-1:0] map_coord(logic signed [COORD_W-1:0] c);
    logic signed [COORD_W:0] s;
    s = (COORD_W + 1)'(c) + (COORD_W + 1)'(COORD_LIM);
    if (c < -(COORD_W)'(COORD_LIM)) s = '0;
    else if (c > (COORD_W)'(COORD_LIM)) s = (COORD_W + 1)'(2 * COORD_LIM);
    return s[COORD_W-1:0];
  endfunction

  // Round half up to Q12 and clamp to zero..one.
  function automatic logic [OUT_W-1:0] finish_ch(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]   r;
    logic [ACC_W-RES_SHIFT:0] q;
    logic [OUT_W-1:0]         res;
    r = (ACC_W + 1)'(acc) + (ACC_W + 1)'(1 << RND_BIT);
    q = r[ACC_W:RES_SHIFT];
    if (r[ACC_W]) res = '0;
    else if (q > (ACC_W - RES_SHIFT + 1)'(ONE_Q12)) res = OUT_W'(ONE_Q12);
    else res = q[OUT_W-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bilinear_image_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image sampler
// Stores an RGB image and returns bilinear samples at normalized coordinates.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     push / full                in_data   (load or sample)
//  result    pop / empty                out_data  (one per sample)
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A load transaction is a single write into the single-port pixel RAM; a sample
// reads its four neighbours from that RAM one per cycle once the result queue
// has room. Reset is synchronous; the pixel RAM is not cleared and needs no sweep.
// Input and result sides stall independently through the internal queues.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire bis_pkg::in_t                  in_data,
  output logic                               full,
  output logic                               empty,
  input  wire logic                          pop,
  output bis_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bis_pkg::CFG_W-1:0]     cfg_data
);
  import bis_pkg::*;

  logic  fq_push;
  cq_t   fq_data;
  logic  fq_full;
  logic  bq_pop;
  cq_t   bq_data;
  logic  bq_empty;
  logic  r_push;
  out_t  r_data;
  logic  r_pop;

  assign r_pop = pop & ~empty;

  bis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (fq_push),
    .q_data    (fq_data),
    .q_full    (fq_full)
  );

  bis_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_data),
    .full  (fq_full),
    .pop   (bq_pop),
    .dout  (bq_data),
    .empty (bq_empty)
  );

  bis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (bq_empty),
    .q_data  (bq_data),
    .q_pop   (bq_pop),
    .r_push  (r_push),
    .r_data  (r_data),
    .r_pop   (r_pop)
  );

  bis_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_data),
    .pop   (r_pop),
    .dout  (out_data),
    .empty (empty)
  );

endmodule
`default_nettype wire

// File: hdl/bis_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: hdl/bis_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sampler front end
// Holds the size registers, accepts transactions, scales sample coordinates
// into pixel space and hands neighbour indices or load addresses onward.
// ----------------------------------------------------------------------------
module bis_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire bis_pkg::in_t                  in_data,
  output logic                               full,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bis_pkg::CFG_W-1:0]     cfg_data,
  output logic                               q_push,
  output bis_pkg::cq_t                       q_data,
  input  wire logic                          q_full
);
  import bis_pkg::*;

  logic [COL_W-1:0]  w_m1;
  logic [ROW_W-1:0]  h_m1;
  logic              f_vld;
  logic              f_sample;
  logic              f_last;
  logic [ADDR_W-1:0] f_addr;
  logic [PIX_W-1:0]  f_pix;
  logic [PU_W-1:0]   f_pu;
  logic [PV_W-1:0]   f_pv;
  logic              accept;
  logic              load_ok;
  logic [COL_W-1:0]  x0;
  logic [ROW_W-1:0]  y0;

  assign cfg_ready = 1'b1;
  assign full      = f_vld & q_full;
  assign accept    = push & ~full;
  assign load_ok   = (int'(in_data.pix_col) < MAX_WIDTH) &&
                     (int'(in_data.pix_row) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1  <= COL_W'(clamp_m1(CFG_W'(256), MAX_WIDTH));
      h_m1  <= ROW_W'(clamp_m1(CFG_W'(256), MAX_HEIGHT));
      f_vld <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_IMAGE_WIDTH) begin
        w_m1 <= COL_W'(clamp_m1(cfg_data, MAX_WIDTH));
      end
      if (cfg_valid && cfg_index == REG_IMAGE_HEIGHT) begin
        h_m1 <= ROW_W'(clamp_m1(cfg_data, MAX_HEIGHT));
      end
      if (accept) begin
        f_vld <= (in_data.cmd == CMD_SAMPLE) | load_ok;
      end else if (q_push) begin
        f_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_sample <= (in_data.cmd == CMD_SAMPLE);
      f_last   <= in_data.last_in;
      f_pix    <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      f_addr   <= ADDR_W'(int'(in_data.pix_row) * MAX_WIDTH + int'(in_data.pix_col));
      f_pu     <= PU_W'(map_coord(in_data.coord_u)) * PU_W'(w_m1);
      f_pv     <= PV_W'(map_coord(in_data.coord_v)) * PV_W'(h_m1);
    end
  end

  assign q_push = f_vld & ~q_full;
  assign x0     = f_pu[POS_SHIFT +: COL_W];
  assign y0     = f_pv[POS_SHIFT +: ROW_W];

  always_comb begin
    q_data.is_sample = f_sample;
    q_data.addr      = f_addr;
    q_data.pix       = f_pix;
    q_data.x0        = x0;
    q_data.x1        = (x0 == w_m1) ? x0 : x0 + COL_W'(1);
    q_data.y0        = y0;
    q_data.y1        = (y0 == h_m1) ? y0 : y0 + ROW_W'(1);
    q_data.fx        = f_pu[3 +: FRAC_W];
    q_data.fy        = f_pv[3 +: FRAC_W];
    q_data.last      = f_last;
  end

endmodule
`default_nettype wire

// File: hdl/bis_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sampler command queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bis_cmdq (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire bis_pkg::cq_t din,
  output logic              full,
  input  wire logic         pop,
  output bis_pkg::cq_t      dout,
  output logic              empty
);
  import bis_pkg::*;

  cq_t              mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wp;
  logic [CQ_AW-1:0] rp;
  logic [CQ_AW:0]   cnt;

  assign full  = (cnt == (CQ_AW + 1)'(CQ_DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wp + CQ_AW'(1);
      end
      if (pop) begin
        rp <= (rp == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rp + CQ_AW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (CQ_AW + 1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (CQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bis_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sampler back end
// Owns the pixel store. Writes loads, reads the four neighbours of a sample
// one per cycle, weights them and accumulates the blended channels.
// ----------------------------------------------------------------------------
module bis_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_empty,
  input  wire bis_pkg::cq_t q_data,
  output logic              q_pop,
  output logic              r_push,
  output bis_pkg::out_t     r_data,
  input  wire logic         r_pop
);
  import bis_pkg::*;

  logic [1:0]               nb;
  logic [RQ_AW:0]           res_cnt;
  logic                     room;
  logic                     issue;
  logic                     start;
  logic                     wr_en;
  logic [ADDR_W-1:0]        ram_addr;
  logic [PIX_W-1:0]         ram_rdata;
  logic [COL_W-1:0]         sel_x;
  logic [ROW_W-1:0]         sel_y;
  logic [FRAC_W:0]          wx;
  logic [FRAC_W:0]          wy;
  logic                     s1_vld;
  logic                     s1_first;
  logic                     s1_end;
  logic                     s1_last;
  logic [WGT_W-1:0]         s1_wgt;
  logic                     s2_vld;
  logic                     s2_first;
  logic                     s2_end;
  logic                     s2_last;
  logic signed [ACC_W-1:0]  s2_prod [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic                     s3_vld;
  logic                     s3_last;

  assign room  = (res_cnt < (RQ_AW + 1)'(RQ_DEPTH));
  assign wr_en = ~q_empty & ~q_data.is_sample;
  assign issue = ~q_empty & q_data.is_sample & ((nb != 2'd0) | room);
  assign start = issue & (nb == 2'd0);
  assign q_pop = wr_en | (issue & (nb == 2'd3));

  assign sel_x    = nb[0] ? q_data.x1 : q_data.x0;
  assign sel_y    = nb[1] ? q_data.y1 : q_data.y0;
  assign ram_addr = wr_en ? q_data.addr :
                    ADDR_W'(int'(sel_y) * MAX_WIDTH + int'(sel_x));
  assign wx = nb[0] ? {1'b0, q_data.fx} : (FRAC_W + 1)'(ONE_Q12) - {1'b0, q_data.fx};
  assign wy = nb[1] ? {1'b0, q_data.fy} : (FRAC_W + 1)'(ONE_Q12) - {1'b0, q_data.fy};

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .addr  (ram_addr),
    .wdata (q_data.pix),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nb      <= 2'd0;
      res_cnt <= '0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
    end else begin
      if (issue) begin
        nb <= nb + 2'd1;
      end
      if (start && !r_pop) begin
        res_cnt <= res_cnt + (RQ_AW + 1)'(1);
      end else if (r_pop && !start) begin
        res_cnt <= res_cnt - (RQ_AW + 1)'(1);
      end
      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld & s2_end;
    end
  end

  always_ff @(posedge clk) begin
    s1_wgt   <= WGT_W'(wx) * WGT_W'(wy);
    s1_first <= (nb == 2'd0);
    s1_end   <= (nb == 2'd3);
    s1_last  <= q_data.last;
    s2_first <= s1_first;
    s2_end   <= s1_end;
    s2_last  <= s1_last;
    s3_last  <= s2_last;
    for (int c = 0; c < 3; c++) begin
      s2_prod[c] <= ACC_W'(signed'({1'b0, s1_wgt})) *
                    ACC_W'(signed'(ram_rdata[PIX_W - 1 - c * CH_W -: CH_W]));
      if (s2_vld) begin
        acc[c] <= (s2_first ? ACC_W'(0) : acc[c]) + s2_prod[c];
      end
    end
  end

  assign r_push = s3_vld;

  always_comb begin
    r_data.red_out   = finish_ch(acc[0]);
    r_data.green_out = finish_ch(acc[1]);
    r_data.blue_out  = finish_ch(acc[2]);
    r_data.last_out  = s3_last;
  end

endmodule
`default_nettype wire

// File: hdl/bis_resq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sampler result queue
// Holds finished samples until they are taken on the result side.
// ----------------------------------------------------------------------------
module bis_resq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bis_pkg::out_t din,
  input  wire logic          pop,
  output bis_pkg::out_t      dout,
  output logic               empty
);
  import bis_pkg::*;

  out_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wp;
  logic [RQ_AW-1:0] rp;
  logic [RQ_AW:0]   cnt;

  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == RQ_AW'(RQ_DEPTH - 1)) ? '0 : wp + RQ_AW'(1);
      end
      if (pop) begin
        rp <= (rp == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rp + RQ_AW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (RQ_AW + 1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (RQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bis_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sampler port checker
// Watches the top-level ports for reset behavior, result range and holding.
// ----------------------------------------------------------------------------
module bis_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          full,
  input wire logic          empty,
  input wire logic          pop,
  input wire bis_pkg::out_t out_data
);
  import bis_pkg::*;

  a_rst_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_rst_full : assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.red_out <= OUT_W'(ONE_Q12) &&
                out_data.green_out <= OUT_W'(ONE_Q12) &&
                out_data.blue_out <= OUT_W'(ONE_Q12)))
    else $error("result channel above one");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before it was taken");

endmodule

bind bilinear_image_sampler_unit bis_chk u_chk (.*);
`default_nettype wire
